// ===== src/shs_pkg.sv =====
// shared types, constants and helpers for the source health supervisor
// used by every module of the block but shs_fifo; depends on nothing
package shs_pkg;

	localparam int MID_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 2;

	localparam int TIME_W = 64;
	localparam int CFG_TIME_W = 51;
	localparam int LADDER_W = 35;

	localparam logic [TIME_W-1:0] ONE_SEC_NS = 64'd1_000_000_000;
	localparam logic [CFG_TIME_W-1:0] NS_PER_MS = 51'd1_000_000;
	localparam logic [CFG_TIME_W-1:0] OPENING_GRACE_NS = 51'd15_000_000_000;
	localparam logic [CFG_TIME_W-1:0] OPENING_TOTAL_NS = 51'd60_000_000_000;
	localparam logic [TIME_W-1:0] OPENING_RESTART_GAP_NS = 64'd10_000_000_000;
	localparam logic [1:0] OPENING_RESTART_MAX = 2'd3;
	localparam logic [3:0] LOST_RESTART_SAT = 4'd15;
	localparam logic [2:0] LADDER_STEPS = 3'd5;
	localparam logic [15:0] RECREATE_SAT = 16'hFFFF;

	// configuration register indexes
	localparam logic [1:0] REG_RESTART_SUPPORTED = 2'd0;
	localparam logic [1:0] REG_RECREATE_BENEFICIAL = 2'd1;
	localparam logic [1:0] REG_FIRST_FRAME_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_LOST_RESTART_LIMIT = 2'd3;
	localparam logic [3:0] LOST_RESTART_LIMIT_RST = 4'd3;

	// health codes
	localparam logic [2:0] H_ACTIVE = 3'd0;
	localparam logic [2:0] H_PAUSED = 3'd1;
	localparam logic [2:0] H_OPENING = 3'd2;
	localparam logic [2:0] H_LOST = 3'd3;
	localparam logic [2:0] H_ERROR = 3'd4;

	// link state codes
	localparam logic [3:0] ST_ACTIVE = 4'd1;
	localparam logic [3:0] ST_PAUSED = 4'd2;
	localparam logic [3:0] ST_CONNECTING = 4'd3;
	localparam logic [3:0] ST_LOST = 4'd4;
	localparam logic [3:0] ST_ERROR = 4'd5;
	localparam logic [3:0] ST_RETRY = 4'd6;

	// classified operation codes
	localparam logic [2:0] OP_NOSRC = 3'd0;
	localparam logic [2:0] OP_ACTIVE = 3'd1;
	localparam logic [2:0] OP_PAUSED = 3'd2;
	localparam logic [2:0] OP_OPENING = 3'd3;
	localparam logic [2:0] OP_LOST = 3'd4;
	localparam logic [2:0] OP_ERROR = 3'd5;
	localparam logic [2:0] OP_ECHO = 3'd6;

	typedef struct packed {
		logic [TIME_W-1:0] now_ns;
		logic [2:0] health;
		logic source_present;
		logic [3:0] prior_state;
	} item_t;

	typedef struct packed {
		logic [3:0] new_state;
		logic do_restart;
		logic do_recreate;
		logic [15:0] recreate_total;
	} result_t;

	typedef struct packed {
		logic [2:0] op;
		logic [TIME_W-1:0] now_ns;
		logic [TIME_W-1:0] gap_deadline;
		logic [3:0] prior_state;
	} cmd_t;

	typedef struct packed {
		logic restart_supported;
		logic recreate_beneficial;
		logic [CFG_TIME_W-1:0] grace_ns;
		logic [CFG_TIME_W-1:0] total_ns;
		logic [3:0] lost_restart_limit;
	} cfg_t;

	// backoff ladder 5/10/15/20/30 s, holding at the last step
	function automatic logic [LADDER_W-1:0] ladder_ns(input logic [2:0] pos);
		logic [LADDER_W-1:0] r;
		begin
			case (pos)
				3'd0: r = 35'd5_000_000_000;
				3'd1: r = 35'd10_000_000_000;
				3'd2: r = 35'd15_000_000_000;
				3'd3: r = 35'd20_000_000_000;
				default: r = 35'd30_000_000_000;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== src/shs_fifo.sv =====
// small register queue for supervisor words
// depends on nothing beyond its type parameter
module shs_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input T din,
	output logic full,
	input logic pop,
	output T dout,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	T mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end
endmodule

// ===== src/shs_front.sv =====
// front end: classifies incoming words and queues them for the back end
// depends on shs_pkg and shs_fifo
module shs_front import shs_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t item,
	output logic full,
	input logic cmd_pop,
	output cmd_t cmd,
	output logic cmd_empty
);
	cmd_t cmd_in;

	always_comb begin
		cmd_in.now_ns = item.now_ns;
		cmd_in.prior_state = item.prior_state;
		cmd_in.gap_deadline = item.now_ns + OPENING_RESTART_GAP_NS;
		if (!item.source_present) begin
			cmd_in.op = OP_NOSRC;
		end else begin
			unique case (item.health)
				H_ACTIVE: cmd_in.op = OP_ACTIVE;
				H_PAUSED: cmd_in.op = OP_PAUSED;
				H_OPENING: cmd_in.op = OP_OPENING;
				H_LOST: cmd_in.op = OP_LOST;
				H_ERROR: cmd_in.op = OP_ERROR;
				default: cmd_in.op = OP_ECHO;
			endcase
		end
	end

	shs_fifo #(.T(cmd_t), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(cmd_in),
		.full(full),
		.pop(cmd_pop),
		.dout(cmd),
		.empty(cmd_empty)
	);
endmodule

// ===== src/shs_back.sv =====
// back end: recovery state update and result generation, one word a cycle
// while the result queue is not full and a word waits; depends on shs_pkg
module shs_back import shs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input cmd_t cmd,
	input logic cmd_empty,
	output logic cmd_pop,
	output logic res_push,
	output result_t res,
	input logic res_full
);
	logic [TIME_W-1:0] opening_start_q, lost_start_q, retry_deadline_q;
	logic [1:0] opening_restarts_q;
	logic [3:0] lost_restarts_q;
	logic [2:0] ladder_pos_q;
	logic [15:0] recreate_count_q;

	logic [TIME_W-1:0] opening_start_d, lost_start_d, retry_deadline_d;
	logic [1:0] opening_restarts_d;
	logic [3:0] lost_restarts_d;
	logic [2:0] ladder_pos_d, ladder_next;
	logic [15:0] recreate_count_d;

	logic [TIME_W-1:0] os_eff, ls_eff, open_elapsed, lost_elapsed, ladder_deadline;
	logic deadline_ok, fire;

	assign fire = ~cmd_empty & ~res_full;
	assign cmd_pop = fire;
	assign res_push = fire;

	assign os_eff = (opening_start_q == '0) ? cmd.now_ns : opening_start_q;
	assign ls_eff = (lost_start_q == '0) ? cmd.now_ns : lost_start_q;
	assign open_elapsed = cmd.now_ns - os_eff;
	assign lost_elapsed = cmd.now_ns - ls_eff;
	assign deadline_ok = (cmd.now_ns >= retry_deadline_q);
	assign ladder_next = (ladder_pos_q < LADDER_STEPS) ? ladder_pos_q + 3'd1 : ladder_pos_q;
	assign ladder_deadline = cmd.now_ns + TIME_W'(ladder_ns(ladder_next));

	always_comb begin
		opening_start_d = opening_start_q;
		lost_start_d = lost_start_q;
		retry_deadline_d = retry_deadline_q;
		opening_restarts_d = opening_restarts_q;
		lost_restarts_d = lost_restarts_q;
		ladder_pos_d = ladder_pos_q;
		recreate_count_d = recreate_count_q;
		res.new_state = cmd.prior_state;
		res.do_restart = 1'b0;
		res.do_recreate = 1'b0;
		unique case (cmd.op) inside
			OP_NOSRC: res.new_state = ST_ERROR;
			OP_ACTIVE, OP_PAUSED: begin
				opening_start_d = '0;
				lost_start_d = '0;
				opening_restarts_d = '0;
				lost_restarts_d = '0;
				ladder_pos_d = '0;
				recreate_count_d = '0;
				res.new_state = (cmd.op == OP_ACTIVE) ? ST_ACTIVE : ST_PAUSED;
			end
			OP_OPENING: begin
				opening_start_d = os_eff;
				if (open_elapsed >= TIME_W'(cfg.total_ns)
						|| opening_restarts_q >= OPENING_RESTART_MAX) begin
					lost_start_d = cmd.now_ns;
					res.new_state = ST_LOST;
				end else begin
					res.new_state = ST_CONNECTING;
					if (open_elapsed >= TIME_W'(cfg.grace_ns) && cfg.restart_supported
							&& deadline_ok) begin
						res.do_restart = 1'b1;
						opening_restarts_d = opening_restarts_q + 2'd1;
						retry_deadline_d = cmd.gap_deadline;
					end
				end
			end
			OP_LOST: begin
				lost_start_d = ls_eff;
				res.new_state = ST_LOST;
				if ((cfg.restart_supported || cfg.recreate_beneficial)
						&& lost_elapsed >= TIME_W'(ladder_ns(ladder_pos_q)) && deadline_ok) begin
					if (cfg.restart_supported && lost_restarts_q < cfg.lost_restart_limit) begin
						res.do_restart = 1'b1;
						if (lost_restarts_q < LOST_RESTART_SAT)
							lost_restarts_d = lost_restarts_q + 4'd1;
						ladder_pos_d = ladder_next;
						retry_deadline_d = ladder_deadline;
						res.new_state = ST_RETRY;
					end else if (!cfg.recreate_beneficial) begin
						lost_restarts_d = '0;
					end else begin
						lost_restarts_d = '0;
						ladder_pos_d = ladder_next;
						retry_deadline_d = ladder_deadline;
						if (recreate_count_q < RECREATE_SAT)
							recreate_count_d = recreate_count_q + 16'd1;
						res.do_recreate = 1'b1;
						res.new_state = ST_RETRY;
					end
				end
			end
			OP_ERROR: begin
				lost_start_d = ls_eff;
				res.new_state = ST_ERROR;
			end
			default: ;
		endcase
		res.recreate_total = recreate_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opening_start_q <= '0;
			lost_start_q <= '0;
			retry_deadline_q <= '0;
			opening_restarts_q <= '0;
			lost_restarts_q <= '0;
			ladder_pos_q <= '0;
			recreate_count_q <= '0;
		end else if (fire) begin
			opening_start_q <= opening_start_d;
			lost_start_q <= lost_start_d;
			retry_deadline_q <= retry_deadline_d;
			opening_restarts_q <= opening_restarts_d;
			lost_restarts_q <= lost_restarts_d;
			ladder_pos_q <= ladder_pos_d;
			recreate_count_q <= recreate_count_d;
		end
	end
endmodule

// ===== src/source_health_supervisor_top.sv =====
// source health supervisor top level: config registers, front, back, result queue
// path: a pushed word is registered in the front queue, updated by the back end and registered in the result queue
// throughput: one word per cycle while the result queue is not full; the back end state update is combinational
// reset: arst_n clears all recovery state, queues empty, config to its defaults
// depends on shs_pkg, shs_front, shs_back and shs_fifo
module source_health_supervisor_top import shs_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	// input word queue
	input logic push,
	input item_t item,
	output logic full,
	// result word queue
	output result_t result,
	output logic empty,
	input logic pop,
	// config write port
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [30:0] cfg_wdata
);
	// config registers; the first-frame timeout is kept as grace and total in ns
	logic restart_supported_q, recreate_beneficial_q;
	logic [CFG_TIME_W-1:0] grace_ns_q, total_ns_q;
	logic [3:0] lost_restart_limit_q;
	logic [CFG_TIME_W-1:0] timeout_ns;
	cfg_t cfg;

	cmd_t cmd;
	logic cmd_empty, cmd_pop;
	logic res_push, res_full;
	result_t res;

	// ms to ns, done once at write time
	assign timeout_ns = CFG_TIME_W'(cfg_wdata) * NS_PER_MS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_supported_q <= 1'b1;
			recreate_beneficial_q <= 1'b1;
			grace_ns_q <= OPENING_GRACE_NS;
			total_ns_q <= OPENING_TOTAL_NS;
			lost_restart_limit_q <= LOST_RESTART_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESTART_SUPPORTED: restart_supported_q <= cfg_wdata[0];
				REG_RECREATE_BENEFICIAL: recreate_beneficial_q <= cfg_wdata[0];
				REG_FIRST_FRAME_TIMEOUT: begin
					// zero falls back to the fixed grace and total windows
					if (cfg_wdata == '0) begin
						grace_ns_q <= OPENING_GRACE_NS;
						total_ns_q <= OPENING_TOTAL_NS;
					end else begin
						grace_ns_q <= timeout_ns;
						total_ns_q <= timeout_ns;
					end
				end
				REG_LOST_RESTART_LIMIT: lost_restart_limit_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.restart_supported = restart_supported_q;
		cfg.recreate_beneficial = recreate_beneficial_q;
		cfg.grace_ns = grace_ns_q;
		cfg.total_ns = total_ns_q;
		cfg.lost_restart_limit = lost_restart_limit_q;
	end

	// front: classify and queue
	shs_front #(.MID_DEPTH(MID_DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.cmd_empty(cmd_empty)
	);

	// back: recovery state machine, stalls only on a full result queue
	shs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.res_push(res_push),
		.res(res),
		.res_full(res_full)
	);

	// result queue decouples the back end from the consumer
	shs_fifo #(.T(result_t), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.din(res),
		.full(res_full),
		.pop(pop),
		.dout(result),
		.empty(empty)
	);
endmodule

// ===== dv/shs_link_checker.sv =====
`timescale 1ns / 1ps
// result checker for the source health supervisor: mirrors the recovery state per word
// and compares every popped result with its prediction; depends on shs_pkg
module shs_link_checker import shs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input item_t item,
	input result_t result,
	input logic empty,
	input logic pop,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [30:0] cfg_wdata,
	output int pending,
	output int mismatches
);

	localparam logic [63:0] SEC_NS = 64'd1_000_000_000;
	localparam logic [63:0] MS_NS = 64'd1_000_000;
	localparam logic [63:0] GRACE_DEF_NS = 64'd15_000_000_000;
	localparam logic [63:0] TOTAL_DEF_NS = 64'd60_000_000_000;
	localparam logic [63:0] REOPEN_GAP_NS = 64'd10_000_000_000;
	localparam logic [1:0] OPEN_TRIES_MAX = 2'd3;
	localparam logic [3:0] LOST_TRIES_CAP = 4'd15;
	localparam logic [2:0] RUNG_TOP = 3'd5;
	localparam logic [15:0] RECREATES_CAP = 16'hFFFF;

	// register copies
	logic restart_ok;
	logic recreate_ok;
	logic [30:0] first_frame_ms;
	logic [3:0] lost_tries_limit;

	// recovery state copies
	logic [63:0] open_since;
	logic [63:0] lost_since;
	logic [63:0] retry_due;
	logic [1:0] open_tries;
	logic [3:0] lost_tries;
	logic [2:0] rung;
	logic [15:0] recreates;

	result_t due_results[$];
	result_t want;
	result_t got;
	int popped_words;

	function automatic logic [63:0] backoff_ns(input logic [2:0] r);
		case (r)
			3'd0: return 64'd5 * SEC_NS;
			3'd1: return 64'd10 * SEC_NS;
			3'd2: return 64'd15 * SEC_NS;
			3'd3: return 64'd20 * SEC_NS;
			default: return 64'd30 * SEC_NS;
		endcase
	endfunction

	task automatic report_bad(input string what, input longint unsigned seen,
		input longint unsigned wanted);
		$display("mismatch on word %0d: %0s got %0h want %0h", popped_words, what, seen,
			wanted);
		mismatches++;
	endtask

	task automatic clear_recovery();
		open_since = '0;
		lost_since = '0;
		open_tries = '0;
		lost_tries = '0;
		recreates = '0;
		rung = '0;
	endtask

	task automatic climb_ladder(input logic [63:0] now);
		if (rung < RUNG_TOP)
			rung++;
		retry_due = now + backoff_ns(rung);
	endtask

	// one tick of the supervisor: updates the state copies, returns the result word
	task automatic supervise(input item_t w, output result_t r);
		logic [63:0] elapsed;
		logic [63:0] grace;
		logic [63:0] total;
		logic [3:0] st;
		logic rs;
		logic rc;
		st = w.prior_state;
		rs = 1'b0;
		rc = 1'b0;
		if (!w.source_present) begin
			st = ST_ERROR;
		end else begin
			case (w.health) inside
				H_ACTIVE, H_PAUSED: begin
					clear_recovery();
					st = (w.health == H_ACTIVE) ? ST_ACTIVE : ST_PAUSED;
				end
				H_OPENING: begin
					if (open_since == '0)
						open_since = w.now_ns;
					elapsed = w.now_ns - open_since;
					if (first_frame_ms != '0) begin
						grace = 64'(first_frame_ms) * MS_NS;
						total = grace;
					end else begin
						grace = GRACE_DEF_NS;
						total = TOTAL_DEF_NS;
					end
					if (elapsed >= total || open_tries >= OPEN_TRIES_MAX) begin
						lost_since = w.now_ns;
						st = ST_LOST;
					end else begin
						st = ST_CONNECTING;
						if (elapsed >= grace && restart_ok && w.now_ns >= retry_due) begin
							rs = 1'b1;
							if (open_tries < OPEN_TRIES_MAX)
								open_tries++;
							retry_due = w.now_ns + REOPEN_GAP_NS;
						end
					end
				end
				H_LOST: begin
					if (lost_since == '0)
						lost_since = w.now_ns;
					st = ST_LOST;
					elapsed = w.now_ns - lost_since;
					if ((restart_ok || recreate_ok) && elapsed >= backoff_ns(rung) &&
						w.now_ns >= retry_due) begin
						if (restart_ok && lost_tries < lost_tries_limit) begin
							rs = 1'b1;
							if (lost_tries < LOST_TRIES_CAP)
								lost_tries++;
							climb_ladder(w.now_ns);
							st = ST_RETRY;
						end else if (!recreate_ok) begin
							lost_tries = '0;
						end else begin
							lost_tries = '0;
							climb_ladder(w.now_ns);
							if (recreates < RECREATES_CAP)
								recreates++;
							rc = 1'b1;
							st = ST_RETRY;
						end
					end
				end
				H_ERROR: begin
					if (lost_since == '0)
						lost_since = w.now_ns;
					st = ST_ERROR;
				end
				default: ;
			endcase
		end
		r.new_state = st;
		r.do_restart = rs;
		r.do_recreate = rc;
		r.recreate_total = recreates;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_ok = 1'b1;
			recreate_ok = 1'b1;
			first_frame_ms = '0;
			lost_tries_limit = 4'd3;
			clear_recovery();
			retry_due = '0;
			due_results.delete();
			popped_words = 0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RESTART_SUPPORTED: restart_ok = cfg_wdata[0];
					REG_RECREATE_BENEFICIAL: recreate_ok = cfg_wdata[0];
					REG_FIRST_FRAME_TIMEOUT: first_frame_ms = cfg_wdata;
					REG_LOST_RESTART_LIMIT: lost_tries_limit = cfg_wdata[3:0];
					default: ;
				endcase
			end
			// a result leaves only after its word has passed both queues, so pop before push
			if (pop && !empty) begin
				got = result;
				if (due_results.size() == 0) begin
					report_bad("unexpected result", 64'(got), 64'd0);
				end else begin
					want = due_results.pop_front();
					if (got.new_state !== want.new_state)
						report_bad("new_state", 64'(got.new_state), 64'(want.new_state));
					if (got.do_restart !== want.do_restart)
						report_bad("do_restart", 64'(got.do_restart), 64'(want.do_restart));
					if (got.do_recreate !== want.do_recreate)
						report_bad("do_recreate", 64'(got.do_recreate), 64'(want.do_recreate));
					if (got.recreate_total !== want.recreate_total)
						report_bad("recreate_total", 64'(got.recreate_total),
							64'(want.recreate_total));
				end
				popped_words++;
			end
			if (push && !full) begin
				supervise(item, want);
				due_results.push_back(want);
			end
			pending <= due_results.size();
		end
	end

endmodule

// ===== dv/source_health_supervisor_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the source health supervisor: clock, reset, word stimulus and verdict
// depends on shs_pkg, source_health_supervisor_top and shs_link_checker
module source_health_supervisor_top_tb;
	import shs_pkg::*;

	localparam logic [63:0] SEC = 64'd1_000_000_000;
	localparam logic [2:0] H_UNKNOWN = 3'd5;
	localparam int PHASE_WORDS = 125;
	localparam int PHASES = 8;
	localparam int RX_HOLD_CYCLES = 200;
	// cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	item_t item = '0;
	logic full;
	result_t result;
	logic empty;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [30:0] cfg_wdata = '0;

	int pending;
	int mismatches;

	// stimulus bookkeeping
	logic [63:0] now_t = '0;
	int words_sent = 0;
	bit no_gaps = 1'b0;
	bit hold_rx = 1'b0;
	bit rx_held = 1'b0;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	source_health_supervisor_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	shs_link_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.result(result),
		.empty(empty),
		.pop(pop),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pending(pending),
		.mismatches(mismatches)
	);

	// watchdog: any handshake or register write resets the count
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL source_health_supervisor_top");
				$finish;
			end
		end
	end

	// push one word: optional idle gap, then hold it until full drops at an edge
	// returns at the accepting edge, so the next call can keep push high
	task automatic send_word(input item_t w);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		words_sent++;
	endtask

	task automatic offer(input logic [63:0] ts, input logic [2:0] h, input logic present,
		input logic [3:0] prior);
		item_t w;
		w.now_ns = ts;
		w.health = h;
		w.source_present = present;
		w.prior_state = prior;
		send_word(w);
	endtask

	// mostly whole seconds so the grace, gap and ladder thresholds get crossed
	function automatic logic [63:0] stride();
		if ($urandom_range(0, 3) != 0)
			return 64'($urandom_range(1, 12)) * SEC;
		return 64'($urandom_range(0, 2_000_000_000));
	endfunction

	task automatic tick(input logic [2:0] h, input logic present);
		now_t = now_t + stride();
		offer(now_t, h, present, 4'($urandom));
	endtask

	// a lost window, sometimes long enough to climb the whole backoff ladder
	task automatic lost_run();
		int n;
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(3, 15);
		repeat (n)
			tick(($urandom_range(0, 9) == 0) ? H_ERROR : H_LOST,
				$urandom_range(0, 19) != 0);
	endtask

	// one random scenario; mostly well formed open/lost sequences with noise mixed in
	task automatic run_scenario();
		int n;
		case ($urandom_range(0, 9)) inside
			[0:3]: begin
				if ($urandom_range(0, 1) != 0)
					tick($urandom_range(0, 1) ? H_ACTIVE : H_PAUSED, 1'b1);
				n = $urandom_range(2, 12);
				repeat (n)
					tick(H_OPENING, $urandom_range(0, 19) != 0);
				if ($urandom_range(0, 2) != 0)
					lost_run();
			end
			[4:6]: lost_run();
			7: tick($urandom_range(0, 1) ? H_ACTIVE : H_PAUSED, 1'b1);
			8: tick(3'($urandom), 1'($urandom));
			default: begin
				// jump the clock: anywhere, just below the wrap, or near the zero sentinel
				case ($urandom_range(0, 2))
					0: now_t = {$urandom, $urandom};
					1: now_t = '1 - 64'($urandom_range(0, 40)) * SEC;
					default: now_t = 64'($urandom_range(0, 3));
				endcase
				offer(now_t, 3'($urandom_range(0, 4)), 1'b1, 4'($urandom));
			end
		endcase
	endtask

	// wait until every expected result has been popped, then settle
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// register settings per phase; in some phases the small registers get junk in their upper bits
	task automatic program_phase(input int ph);
		logic [30:0] junk;
		junk = 31'($urandom);
		drain();
		case (ph)
			1: begin
				write_reg(REG_RESTART_SUPPORTED, {junk[30:1], 1'b0});
				write_reg(REG_RECREATE_BENEFICIAL, {junk[30:1], 1'b1});
				write_reg(REG_FIRST_FRAME_TIMEOUT, 31'd0);
				write_reg(REG_LOST_RESTART_LIMIT, {junk[30:4], 4'd0});
			end
			2: begin
				write_reg(REG_RESTART_SUPPORTED, {junk[30:1], 1'b1});
				write_reg(REG_RECREATE_BENEFICIAL, {junk[30:1], 1'b0});
				write_reg(REG_FIRST_FRAME_TIMEOUT, 31'd1);
				write_reg(REG_LOST_RESTART_LIMIT, {junk[30:4], 4'd15});
			end
			3: begin
				write_reg(REG_RESTART_SUPPORTED, 31'd0);
				write_reg(REG_RECREATE_BENEFICIAL, 31'd0);
				write_reg(REG_FIRST_FRAME_TIMEOUT, 31'h7FFF_FFFF);
				write_reg(REG_LOST_RESTART_LIMIT, {junk[30:4], 4'd3});
			end
			4: begin
				write_reg(REG_RESTART_SUPPORTED, 31'h7FFF_FFFF);
				write_reg(REG_RECREATE_BENEFICIAL, 31'h7FFF_FFFF);
				write_reg(REG_FIRST_FRAME_TIMEOUT, 31'($urandom_range(2000, 30000)));
				write_reg(REG_LOST_RESTART_LIMIT, {junk[30:4], 4'($urandom)});
			end
			5: begin
				write_reg(REG_FIRST_FRAME_TIMEOUT, 31'd0);
				write_reg(REG_LOST_RESTART_LIMIT, 31'd15);
			end
			6: write_reg(REG_LOST_RESTART_LIMIT, 31'd0);
			default: begin
				write_reg(REG_RESTART_SUPPORTED, 31'($urandom));
				write_reg(REG_RECREATE_BENEFICIAL, 31'($urandom));
				write_reg(REG_FIRST_FRAME_TIMEOUT,
					$urandom_range(0, 1) ? 31'd0 : 31'($urandom_range(1000, 60000)));
				write_reg(REG_LOST_RESTART_LIMIT, 31'($urandom));
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	// receiver: random pop gaps, one long hold-off to back the block up into full
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx && !rx_held) begin
				rx_held = 1'b1;
				pop <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			gap = no_gaps ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		int start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words with the reset settings
		// opening stamped at time zero keeps the start unset
		offer(64'd0, H_OPENING, 1'b1, 4'd0);
		// no source wins over everything, the other fields at their top
		offer('1, 3'b111, 1'b0, 4'hF);
		// unknown health codes echo the prior state
		offer(SEC, H_UNKNOWN, 1'b1, 4'd9);
		offer(SEC, H_UNKNOWN + 3'd1, 1'b1, 4'd0);
		offer(SEC, H_UNKNOWN + 3'd2, 1'b1, 4'hF);
		offer(SEC, H_ACTIVE, 1'b1, 4'd0);
		// opening: grace, throttled restarts, then lost after three restarts
		offer(100 * SEC, H_OPENING, 1'b1, 4'd3);
		offer(115 * SEC, H_OPENING, 1'b1, 4'd3);
		offer(120 * SEC, H_OPENING, 1'b1, 4'd3);
		offer(125 * SEC, H_OPENING, 1'b1, 4'd3);
		offer(135 * SEC, H_OPENING, 1'b1, 4'd3);
		offer(136 * SEC, H_OPENING, 1'b1, 4'd3);
		// lost: cheap restarts up the ladder until the restart limit is reached
		offer(137 * SEC, H_LOST, 1'b1, 4'd4);
		offer(141 * SEC, H_LOST, 1'b1, 4'd4);
		offer(151 * SEC, H_LOST, 1'b1, 4'd4);
		offer(166 * SEC, H_LOST, 1'b1, 4'd4);
		offer(186 * SEC, H_LOST, 1'b1, 4'd4);
		offer(190 * SEC, H_ERROR, 1'b1, 4'd4);
		offer(191 * SEC, H_LOST, 1'b0, 4'd4);
		offer(195 * SEC, H_PAUSED, 1'b1, 4'd6);
		// opening across the 64-bit wrap
		offer('1 - 20 * SEC, H_OPENING, 1'b1, 4'd3);
		offer(20 * SEC, H_OPENING, 1'b1, 4'd3);
		offer(25 * SEC, H_LOST, 1'b1, 4'd3);
		offer(64'd1, H_ERROR, 1'b1, 4'd5);
		now_t = 200 * SEC;

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0)
				program_phase(ph);
			no_gaps = (ph % 3 == 2);
			// long receiver stall while the sender keeps offering
			if (ph == 2)
				hold_rx = 1'b1;
			start = words_sent;
			while (words_sent - start < PHASE_WORDS)
				run_scenario();
		end

		drain();
		if (mismatches == 0)
			$display("PASS source_health_supervisor_top");
		else
			$display("FAIL source_health_supervisor_top");
		$finish;
	end

endmodule

// ===== files.f =====
src/shs_pkg.sv
src/shs_fifo.sv
src/shs_front.sv
src/shs_back.sv
src/source_health_supervisor_top.sv
dv/shs_link_checker.sv
dv/source_health_supervisor_top_tb.sv
